// ===== design/text_console_cell_writer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text console cell writer
// Clocked assertion helpers that disappear when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TCCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TCCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TCCW_ASSERT(lbl, prop, msg)
`define TCCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Grid geometry, field widths, codes and shared types of the console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int PTR_W      = $clog2(CELL_COUNT + 1);

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTR   = 1'b1;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0d;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0f;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, BLANK_CHAR};

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [COL_W-1:0]  cursor_col_out;
    logic              scrolled;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(int'(r) * COLUMNS + int'(c));
  endfunction

endpackage

`default_nettype wire

// ===== design/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text-mode console grid with cursor, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// After reset the block blanks all 2000 cells, one per cycle, and holds
// s_axis_tready low until that sweep ends; configuration writes are taken
// meanwhile. For an ordinary write, carriage return, backspace, newline
// without scroll or a cell read, the sequencer goes from idle through an
// execute state to the result state, and the next item can be taken the
// cycle after the result leaves the sequencer. A scroll adds a copy pass
// that moves each cell below the top row one row higher and a blanking
// pass over the bottom row, and a clear adds a blanking pass over the whole
// grid, because every cell move goes through the single write port of
// the grid memory. The result register lets one finished result wait while
// the next item is already being worked on.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cell_writer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [tccw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tccw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // char_code[7:0], read_row[12:8], read_col[19:13], zero [23:20]
  input  wire logic [23:0]                      s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // cell_value[15:0], cursor_row_out[20:16], cursor_col_out[27:21],
  // scrolled[28], zero [31:29]
  output logic [31:0]                           m_axis_tdata
);

  logic                          enable_q;
  logic [tccw_pkg::ATTR_W-1:0]   attr_q;
  logic                          out_valid_q;
  tccw_pkg::res_t                out_q;

  tccw_pkg::item_t               item;
  tccw_pkg::res_t                res;
  logic                          res_valid;
  logic                          res_ready;
  tccw_pkg::ram_req_t            ram_req;
  logic [tccw_pkg::CELL_W-1:0]   ram_rdata;

  assign item.func      = s_axis_tuser;
  assign item.char_code = s_axis_tdata[7:0];
  assign item.read_row  = s_axis_tdata[12:8];
  assign item.read_col  = s_axis_tdata[19:13];

  assign res_ready = !out_valid_q || m_axis_tready;

  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .enable_i    (enable_q),
    .attr_i      (attr_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  tccw_cell_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      attr_q   <= tccw_pkg::RESET_ATTR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tccw_pkg::REG_ENABLE: enable_q <= cfg_data_i[0];
        tccw_pkg::REG_ATTR:   attr_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.scrolled, out_q.cursor_col_out,
                          out_q.cursor_row_out, out_q.cell_value};

endmodule

`default_nettype wire

// ===== design/tccw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tccw_cell_ram
// Character grid storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tccw_cell_ram (
  input  wire logic                           clk_i,
  input  wire tccw_pkg::ram_req_t             req_i,
  output logic [tccw_pkg::CELL_W-1:0]         rdata_o
);

  logic [tccw_pkg::CELL_W-1:0] mem_q [tccw_pkg::CELL_COUNT];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/tccw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer that decodes each operation, moves the cursor and drives the
// grid memory through writes, reads, scroll copies and blanking sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_cell_writer_assert.svh"

module tccw_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire tccw_pkg::item_t                in_item_i,
  input  wire logic                           enable_i,
  input  wire logic [tccw_pkg::ATTR_W-1:0]    attr_i,
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output tccw_pkg::res_t                      res_o,
  output tccw_pkg::ram_req_t                  ram_req_o,
  input  wire logic [tccw_pkg::CELL_W-1:0]    ram_rdata_i
);

  typedef enum logic [6:0] {
    ST_INIT        = 7'b0000001,
    ST_IDLE        = 7'b0000010,
    ST_EXEC        = 7'b0000100,
    ST_SCROLL_COPY = 7'b0001000,
    ST_SCROLL_BLNK = 7'b0010000,
    ST_CLEAR       = 7'b0100000,
    ST_RESP        = 7'b1000000
  } state_e;

  localparam logic [tccw_pkg::PTR_W-1:0] PTR_LAST =
    tccw_pkg::PTR_W'(tccw_pkg::CELL_COUNT - 1);
  localparam logic [tccw_pkg::PTR_W-1:0] PTR_END =
    tccw_pkg::PTR_W'(tccw_pkg::CELL_COUNT);
  localparam logic [tccw_pkg::PTR_W-1:0] PTR_ROW1 =
    tccw_pkg::PTR_W'(tccw_pkg::COLUMNS);
  localparam logic [tccw_pkg::PTR_W-1:0] PTR_BOTTOM =
    tccw_pkg::PTR_W'(tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS);
  localparam logic [tccw_pkg::ROW_W-1:0] ROW_LAST = tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1);
  localparam logic [tccw_pkg::COL_W-1:0] COL_LAST = tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1);

  state_e                           state_q, state_d;
  tccw_pkg::item_t                  item_q, item_d;
  logic [tccw_pkg::ROW_W-1:0]       row_q, row_d;
  logic [tccw_pkg::COL_W-1:0]       col_q, col_d;
  logic                             scrolled_q, scrolled_d;
  logic                             rd_hit_q, rd_hit_d;
  logic [tccw_pkg::PTR_W-1:0]       ptr_q, ptr_d;
  logic                             pend_q, pend_d;
  logic [tccw_pkg::ADDR_W-1:0]      pend_addr_q, pend_addr_d;

  logic                             in_fire;
  logic [tccw_pkg::CELL_W-1:0]      blank_cell;
  logic [tccw_pkg::COL_W-1:0]       bs_col;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign blank_cell = {attr_i, tccw_pkg::BLANK_CHAR};
  assign bs_col     = (col_q == '0) ? '0 : col_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    row_d       = row_q;
    col_d       = col_q;
    scrolled_d  = scrolled_q;
    rd_hit_d    = rd_hit_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    ram_req_o   = '0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_INIT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = ptr_q[tccw_pkg::ADDR_W-1:0];
        ram_req_o.wdata = tccw_pkg::RESET_CELL;
        ptr_d           = ptr_q + 1'b1;
        if (ptr_q == PTR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          item_d     = in_item_i;
          scrolled_d = 1'b0;
          rd_hit_d   = 1'b0;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_RESP;
        case (item_q.func)
          tccw_pkg::FUNC_WRITE: begin
            if (enable_i) begin
              case (item_q.char_code)
                tccw_pkg::CH_LF: begin
                  col_d = '0;
                  if (row_q == ROW_LAST) begin
                    scrolled_d = 1'b1;
                    ptr_d      = PTR_ROW1;
                    pend_d     = 1'b0;
                    state_d    = ST_SCROLL_COPY;
                  end else begin
                    row_d = row_q + 1'b1;
                  end
                end
                tccw_pkg::CH_CR: begin
                  col_d = '0;
                end
                tccw_pkg::CH_BS: begin
                  col_d           = bs_col;
                  ram_req_o.we    = 1'b1;
                  ram_req_o.waddr = tccw_pkg::cell_addr(row_q, bs_col);
                  ram_req_o.wdata = blank_cell;
                end
                default: begin
                  ram_req_o.we    = 1'b1;
                  ram_req_o.waddr = tccw_pkg::cell_addr(row_q, col_q);
                  ram_req_o.wdata = {attr_i, item_q.char_code};
                  if (col_q == COL_LAST) begin
                    col_d = '0;
                    if (row_q == ROW_LAST) begin
                      scrolled_d = 1'b1;
                      ptr_d      = PTR_ROW1;
                      pend_d     = 1'b0;
                      state_d    = ST_SCROLL_COPY;
                    end else begin
                      row_d = row_q + 1'b1;
                    end
                  end else begin
                    col_d = col_q + 1'b1;
                  end
                end
              endcase
            end
          end
          tccw_pkg::FUNC_READ: begin
            if (item_q.read_row < tccw_pkg::ROW_W'(tccw_pkg::ROWS) &&
                item_q.read_col < tccw_pkg::COL_W'(tccw_pkg::COLUMNS)) begin
              rd_hit_d        = 1'b1;
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = tccw_pkg::cell_addr(item_q.read_row, item_q.read_col);
            end
          end
          tccw_pkg::FUNC_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            ptr_d   = '0;
            state_d = ST_CLEAR;
          end
          default: begin
            state_d = ST_RESP;
          end
        endcase
      end
      ST_SCROLL_COPY: begin
        // Each cell is read, and its data is written one row higher in the cycle after the read.
        if (pend_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = pend_addr_q;
          ram_req_o.wdata = ram_rdata_i;
        end
        if (ptr_q != PTR_END) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = ptr_q[tccw_pkg::ADDR_W-1:0];
          pend_d          = 1'b1;
          pend_addr_d     = tccw_pkg::ADDR_W'(ptr_q - PTR_ROW1);
          ptr_d           = ptr_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          ptr_d   = PTR_BOTTOM;
          state_d = ST_SCROLL_BLNK;
        end
      end
      ST_SCROLL_BLNK, ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = ptr_q[tccw_pkg::ADDR_W-1:0];
        ram_req_o.wdata = blank_cell;
        ptr_d           = ptr_q + 1'b1;
        if (ptr_q == PTR_LAST) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.cell_value     = rd_hit_q ? ram_rdata_i : '0;
  assign res_o.cursor_row_out = row_q;
  assign res_o.cursor_col_out = col_q;
  assign res_o.scrolled       = scrolled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      row_q      <= '0;
      col_q      <= '0;
      scrolled_q <= 1'b0;
      rd_hit_q   <= 1'b0;
      ptr_q      <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      scrolled_q <= scrolled_d;
      rd_hit_q   <= rd_hit_d;
      ptr_q      <= ptr_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    pend_addr_q <= pend_addr_d;
  end

  `TCCW_ASSERT(a_fire_to_exec, in_fire |=> (state_q == ST_EXEC), "accepted transfer not executed")
  `TCCW_ASSERT(a_cursor_range, res_valid_o |-> (row_q <= ROW_LAST && col_q <= COL_LAST),
               "cursor outside grid at result")
  `TCCW_ASSERT(a_copy_dest, (state_q == ST_SCROLL_COPY && ram_req_o.we) |->
               (ram_req_o.waddr < tccw_pkg::ADDR_W'(tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS)),
               "scroll copy wrote into bottom row")
  `TCCW_ASSERT(a_scroll_flag, (state_q == ST_SCROLL_COPY) |-> scrolled_q,
               "scroll pass without scrolled flag")
  `TCCW_ASSERT(a_no_accept_busy, (state_q != ST_IDLE) |-> !in_ready_o,
               "input ready while busy")

endmodule

`default_nettype wire
